// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL; clocked on clk, held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/casq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// casq_pkg
// Types and constants of the class-aware service queue.
// ----------------------------------------------------------------------------
package casq_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ENQ         = 2'd0,
        OP_SERVE_HEAD  = 2'd1,
        OP_SERVE_CLASS = 2'd2,
        OP_PEEK        = 2'd3
    } casq_op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } casq_status_t;

    localparam logic [1:0] CLS_STUDENT = 2'd0;
    localparam logic [1:0] CLS_PARENT  = 2'd1;
    localparam logic [1:0] CLS_TEACHER = 2'd2;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } casq_state_t;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  cls;
    } casq_entry_t;

    typedef struct packed {
        logic load;   // take the incoming item
        logic shift;  // take the neighbour's entry
    } casq_cell_ctrl_t;

endpackage

// ===== hdl/casq_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// casq_req_if
// Request channel: one operation per item.
// ----------------------------------------------------------------------------
interface casq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] entry_id;
    logic [1:0]  entry_class;
    logic [6:0]  position;

    modport source (output valid, output op, output entry_id, output entry_class,
                    output position, input ready);
    modport sink   (input valid, input op, input entry_id, input entry_class,
                    input position, output ready);
endinterface

// ===== hdl/casq_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// casq_rsp_if
// Response channel: one result item per request.
// ----------------------------------------------------------------------------
interface casq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] result_id;
    logic [1:0]  result_class;
    logic [7:0]  queue_length;
    logic [15:0] served_students;
    logic [15:0] served_parents;
    logic [15:0] served_teachers;

    modport source (output valid, output status, output result_id, output result_class,
                    output queue_length, output served_students, output served_parents,
                    output served_teachers, input ready);
    modport sink   (input valid, input status, input result_id, input result_class,
                    input queue_length, input served_students, input served_parents,
                    input served_teachers, output ready);
endinterface

// ===== hdl/casq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// casq_cell
// One queue slot: holds an entry, loads a new one or takes its neighbour's.
// ----------------------------------------------------------------------------
module casq_cell
    import casq_pkg::*;
(
    input  logic            clk,
    input  casq_cell_ctrl_t ctrl,
    input  casq_entry_t     new_entry,
    input  casq_entry_t     nbr_entry,
    input  logic [1:0]      want_cls,
    output casq_entry_t     entry,
    output logic            cls_match
);

    casq_entry_t entry_reg;
    casq_entry_t entry_next;

    always_comb
    begin
        priority if (ctrl.shift)
        begin
            entry_next = nbr_entry;
        end
        else if (ctrl.load)
        begin
            entry_next = new_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry     = entry_reg;
    assign cls_match = (entry_reg.cls == want_cls);

endmodule

// ===== hdl/class_aware_service_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_aware_service_queue
// Bounded FIFO of tagged entries with serve-by-class, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per item: enqueue, serve head, serve the oldest
//   entry of a class, or peek a position. rsp returns exactly one result item
//   per request with status, the entry served or peeked, the length after the
//   operation and the three saturating served counters.
// Timing:
//   For each item, the accept cycle registers the request, the
//   execute cycle matches every cell in parallel, picks the first hit with a
//   prefix-OR mask and shifts the cells from the hit onwards down by one
//   in a single step. The result is registered at the end of the execute
//   cycle and is on rsp the cycle after; no new item is taken while one executes.
// Reset:
//   Length and counters clear; slot contents are not reset and are only ever
//   read below the current length. No clearing pass is needed.
// Stall:
//   A result waits in the output register while rsp.ready is low; a new item
//   is accepted only once that register is free or being emptied that cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module class_aware_service_queue
    import casq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    casq_req_if.sink    req,
    casq_rsp_if.source  rsp
);

    casq_state_t state_reg;
    casq_state_t state_next;
    logic        accept;
    logic        exec_en;

    casq_op_t    op_reg;
    casq_entry_t new_reg;
    logic [6:0]  pos_reg;

    logic [LEN_W-1:0] occ_reg;
    logic [LEN_W-1:0] occ_next;
    logic [15:0]      stu_reg;
    logic [15:0]      par_reg;
    logic [15:0]      tea_reg;

    logic         rsp_valid_reg;
    casq_status_t status_reg;
    casq_entry_t  res_reg;
    logic [7:0]   len_reg;

    casq_entry_t     cell_entry [QUEUE_DEPTH];
    logic            cell_match [QUEUE_DEPTH];
    casq_cell_ctrl_t cell_ctrl  [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] hit;
    logic [QUEUE_DEPTH-1:0] tail_mask;
    logic [QUEUE_DEPTH-1:0] sel;
    logic                   found;
    logic                   is_serve;
    logic                   serve_go;
    logic                   enq_go;
    logic                   full;
    casq_entry_t            hit_entry;
    casq_status_t           status_next;

    // ---------------- control ----------------
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        exec_en   = 1'b0;
        unique case (state_reg)
            S_IDLE:  req.ready = !rsp_valid_reg || rsp.ready;
            S_EXEC:  exec_en   = 1'b1;
            default: req.ready = 1'b0;
        endcase
    end

    assign accept = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= casq_op_t'(req.op);
            new_reg.id  <= req.entry_id;
            new_reg.cls <= req.entry_class;
            pos_reg     <= req.position;
        end
    end

    // ---------------- cell row ----------------
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic occupied;
        logic cond;

        assign occupied = (occ_reg > LEN_W'(i));

        always_comb
        begin
            unique case (op_reg)
                OP_SERVE_HEAD:  cond = (i == 0);
                OP_SERVE_CLASS: cond = cell_match[i];
                OP_PEEK:        cond = (32'(pos_reg) == i);
                default:        cond = 1'b0;
            endcase
        end

        assign hit[i]             = occupied && cond;
        assign cell_ctrl[i].shift = serve_go && tail_mask[i];
        assign cell_ctrl[i].load  = enq_go && (occ_reg == LEN_W'(i));

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            casq_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl[i]),
                .new_entry (new_reg),
                .nbr_entry ('0),
                .want_cls  (new_reg.cls),
                .entry     (cell_entry[i]),
                .cls_match (cell_match[i])
            );
        end
        else
        begin : g_mid
            casq_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl[i]),
                .new_entry (new_reg),
                .nbr_entry (cell_entry[i+1]),
                .want_cls  (new_reg.cls),
                .entry     (cell_entry[i]),
                .cls_match (cell_match[i])
            );
        end
    end

    // first hit and everything behind it
    always_comb
    begin
        tail_mask[0] = hit[0];
        for (int i = 1; i < QUEUE_DEPTH; i++)
        begin
            tail_mask[i] = tail_mask[i-1] | hit[i];
        end
    end

    assign sel   = hit & ~{tail_mask[QUEUE_DEPTH-2:0], 1'b0};
    assign found = |hit;

    always_comb
    begin
        hit_entry = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            hit_entry = hit_entry | (sel[i] ? cell_entry[i] : '0);
        end
    end

    assign full     = (occ_reg >= LEN_W'(QUEUE_DEPTH));
    assign is_serve = (op_reg == OP_SERVE_HEAD) || (op_reg == OP_SERVE_CLASS);
    assign serve_go = exec_en && is_serve && found;
    assign enq_go   = exec_en && (op_reg == OP_ENQ) && !full;

    always_comb
    begin
        unique case (op_reg)
            OP_ENQ:         status_next = full ? ST_FULL : ST_DONE;
            OP_SERVE_HEAD,
            OP_SERVE_CLASS: status_next = found ? ST_DONE : ST_NOT_FOUND;
            OP_PEEK:        status_next = found ? ST_DONE : ST_RANGE;
            default:        status_next = ST_DONE;
        endcase
    end

    always_comb
    begin
        priority if (serve_go)
        begin
            occ_next = occ_reg - 1'b1;
        end
        else if (enq_go)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else
        begin
            occ_next = occ_reg;
        end
    end

    // ---------------- length and counters ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            stu_reg <= '0;
            par_reg <= '0;
            tea_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (serve_go)
            begin
                if (hit_entry.cls == CLS_STUDENT && stu_reg != 16'hFFFF)
                begin
                    stu_reg <= stu_reg + 16'd1;
                end
                if (hit_entry.cls == CLS_PARENT && par_reg != 16'hFFFF)
                begin
                    par_reg <= par_reg + 16'd1;
                end
                if (hit_entry.cls == CLS_TEACHER && tea_reg != 16'hFFFF)
                begin
                    tea_reg <= tea_reg + 16'd1;
                end
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (exec_en)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_en)
        begin
            status_reg <= status_next;
            res_reg    <= (found && op_reg != OP_ENQ) ? hit_entry : '0;
            len_reg    <= occ_next[7:0];
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.result_id       = res_reg.id;
    assign rsp.result_class    = res_reg.cls;
    assign rsp.queue_length    = len_reg;
    assign rsp.served_students = stu_reg;
    assign rsp.served_parents  = par_reg;
    assign rsp.served_teachers = tea_reg;

    // ---------------- checks ----------------
    `ASSERT_CLK(a_occ_bound, occ_reg <= LEN_W'(QUEUE_DEPTH), "length beyond queue depth")
    `ASSERT_NEXT(a_accept_exec, accept, state_reg == S_EXEC, "accepted item not executed")
    `ASSERT_NEXT(a_exec_result, exec_en, rsp_valid_reg, "execute cycle left no result")
    `ASSERT_NEXT(a_occ_hold, !exec_en, $stable(occ_reg), "length moved outside execute")
    `ASSERT_CLK(a_one_hit, $onehot0(sel), "more than one cell selected")

endmodule
